// ----- hw/rtl/ttf_pkg.sv -----
// shared types and constants of the triangle tangent frame block
// no dependencies; used by the channel interfaces and the top level
package ttf_pkg;

  localparam int CoordW = 24;
  localparam int VecW   = 31;
  localparam int NrmW   = 16;
  localparam int LenW   = 64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [VecW-1:0]   vec_t;
  typedef logic signed [NrmW-1:0]   nrm_t;

  localparam logic [NrmW-1:0] UnitQ14 = 16'd16384;

  // vector slots of the working set
  localparam logic [2:0] VEdge1  = 3'd0;
  localparam logic [2:0] VEdge2  = 3'd1;
  localparam logic [2:0] VTex1   = 3'd2;
  localparam logic [2:0] VTex2   = 3'd3;
  localparam logic [2:0] VTan    = 3'd4;
  localparam logic [2:0] VBitan  = 3'd5;

endpackage

// ----- hw/rtl/ttf_vtx_if.sv -----
// vertex channel: valid/ready handshake with position and texture coordinate
// depends on ttf_pkg
interface ttf_vtx_if;
  logic           valid;
  logic           ready;
  ttf_pkg::coord_t pos_x;
  ttf_pkg::coord_t pos_y;
  ttf_pkg::coord_t pos_z;
  ttf_pkg::coord_t tex_u;
  ttf_pkg::coord_t tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ----- hw/rtl/ttf_frm_if.sv -----
// result channel: valid/ready handshake with unit tangent, bitangent and flag
// depends on ttf_pkg
interface ttf_frm_if;
  logic          valid;
  logic          ready;
  ttf_pkg::nrm_t tangent_x;
  ttf_pkg::nrm_t tangent_y;
  ttf_pkg::nrm_t tangent_z;
  ttf_pkg::nrm_t bitangent_x;
  ttf_pkg::nrm_t bitangent_y;
  ttf_pkg::nrm_t bitangent_z;
  logic          degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, output ready);
endinterface

// ----- hw/rtl/triangle_tangent_frame.sv -----
// triangle tangent frame: the first two vertices of a triangle are taken one per cycle
// the third vertex starts six vector normalizations on one shared 32x32 multiplier,
// a bit-per-cycle square root and divider; a zero-length vector ends its normalization early
// ready stays low while the sequencer works; the final state waits for the output register
// synchronous active-low reset clears the sequencer, the vertex count and out valid
module triangle_tangent_frame (
  input  logic      clk,
  input  logic      rst_n,
  ttf_vtx_if.sink   in_ch,
  ttf_frm_if.source out_ch
);
  import ttf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SHF  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIVI = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DET0 = 4'd7;
  localparam logic [3:0] S_DET1 = 4'd8;
  localparam logic [3:0] S_DETC = 4'd9;
  localparam logic [3:0] S_CMB  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  coord_t     hold_a_r [5];
  coord_t     hold_b_r [5];
  coord_t     cur      [5];
  vec_t       vec_r [6][3];
  vec_t       vec_nxt [6][3];
  nrm_t       nrm_r [6][3];
  nrm_t       nrm_nxt [6][3];
  logic [2:0] vi_r, vi_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] root_r, root_nxt;
  logic [LenW-1:0] bit_r, bit_nxt;
  logic [31:0] magsh_r [3];
  logic [31:0] magsh_nxt [3];
  logic [33:0] rem_r, rem_nxt;
  logic [15:0] qn_r, qn_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic neg_r, neg_nxt;
  logic deg_r, deg_nxt;
  logic out_valid_r, out_valid_nxt;
  nrm_t out_t_r [3];
  nrm_t out_b_r [3];
  logic out_deg_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  vec_t       cur_comp;
  logic [30:0] mag;
  logic [LenW-1:0] sq_sum;
  logic [47:0] num_w;
  logic [32:0] dvs;
  logic [33:0] trial;
  logic        qbit;
  logic [15:0] qfin, qclamp;
  logic signed [33:0] comb_v;
  logic        in_fire;
  logic        out_fire;
  logic        fin_go;

  assign cur[0] = in_ch.pos_x;
  assign cur[1] = in_ch.pos_y;
  assign cur[2] = in_ch.pos_z;
  assign cur[3] = in_ch.tex_u;
  assign cur[4] = in_ch.tex_v;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  // output register free this cycle
  assign fin_go   = !out_valid_r || out_fire;

  // shared multiplier and its operand selection
  assign cur_comp = vec_r[vi_r][k_r];
  assign mag      = cur_comp[VecW-1] ? 31'(-cur_comp) : 31'(cur_comp);
  assign prod     = mul_a * mul_b;

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (state_r)
      S_SQ: begin
        mul_a = signed'({1'b0, mag});
        mul_b = signed'({1'b0, mag});
      end
      S_DET0: begin
        mul_a = 32'(nrm_r[VTex1][0]);
        mul_b = 32'(nrm_r[VTex2][1]);
      end
      S_DET1: begin
        mul_a = 32'(nrm_r[VTex1][1]);
        mul_b = 32'(nrm_r[VTex2][0]);
      end
      S_CMB: begin
        unique case (ph_r)
          2'd0: begin
            mul_a = 32'(nrm_r[VTex2][1]);
            mul_b = 32'(nrm_r[VEdge1][k_r]);
          end
          2'd1: begin
            mul_a = 32'(nrm_r[VTex1][1]);
            mul_b = 32'(nrm_r[VEdge2][k_r]);
          end
          2'd2: begin
            mul_a = 32'(nrm_r[VTex1][0]);
            mul_b = 32'(nrm_r[VEdge2][k_r]);
          end
          default: begin
            mul_a = 32'(nrm_r[VTex2][0]);
            mul_b = 32'(nrm_r[VEdge1][k_r]);
          end
        endcase
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  // divider and square root datapath
  assign sq_sum = root_r + bit_r;
  assign num_w  = {1'b0, magsh_r[k_r], 15'd0} + {16'd0, root_r[31:0]};
  assign dvs    = {root_r[31:0], 1'b0};
  assign trial  = {rem_r[32:0], qn_r[15]};
  assign qbit   = trial >= {1'b0, dvs};
  assign qfin   = {qn_r[14:0], qbit};
  assign qclamp = (qfin > UnitQ14) ? UnitQ14 : qfin;
  assign comb_v = acc_r - 34'(prod);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    vec_nxt       = vec_r;
    nrm_nxt       = nrm_r;
    vi_nxt        = vi_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    magsh_nxt     = magsh_r;
    rem_nxt       = rem_r;
    qn_nxt        = qn_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    deg_nxt       = deg_r;
    out_valid_nxt = out_valid_r && !out_fire;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (slot_r == 2'd2) begin
            slot_nxt = 2'd0;
            for (int i = 0; i < 3; i++) begin
              vec_nxt[VEdge1][i] = VecW'(hold_b_r[i]) - VecW'(hold_a_r[i]);
              vec_nxt[VEdge2][i] = VecW'(cur[i]) - VecW'(hold_a_r[i]);
            end
            for (int i = 0; i < 2; i++) begin
              vec_nxt[VTex1][i] = VecW'(hold_b_r[3+i]) - VecW'(hold_a_r[3+i]);
              vec_nxt[VTex2][i] = VecW'(cur[3+i]) - VecW'(hold_a_r[3+i]);
            end
            vec_nxt[VTex1][2] = '0;
            vec_nxt[VTex2][2] = '0;
            vi_nxt    = VEdge1;
            k_nxt     = 2'd0;
            len_nxt   = '0;
            deg_nxt   = 1'b0;
            state_nxt = S_SQ;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      // sum of squares, one component a cycle
      S_SQ: begin
        len_nxt          = len_r + 64'(unsigned'(prod));
        magsh_nxt[k_r]   = {1'b0, mag};
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_CHK;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_CHK: begin
        if (len_r == '0) begin
          deg_nxt = 1'b1;
          for (int i = 0; i < 3; i++) nrm_nxt[vi_r][i] = '0;
          if (vi_r == VTex2) begin
            state_nxt = S_FIN;
          end else if (vi_r == VBitan) begin
            state_nxt = S_FIN;
          end else begin
            vi_nxt    = vi_r + 3'd1;
            len_nxt   = '0;
            state_nxt = S_SQ;
          end
        end else begin
          state_nxt = S_SHF;
        end
      end
      // scale up by four until the top nibble is set
      S_SHF: begin
        if (len_r[LenW-1:LenW-4] != 4'd0) begin
          root_nxt  = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = S_SQRT;
        end else begin
          len_nxt = {len_r[LenW-3:0], 2'b00};
          for (int i = 0; i < 3; i++) magsh_nxt[i] = {magsh_r[i][30:0], 1'b0};
        end
      end
      // integer square root, one result bit a cycle
      S_SQRT: begin
        if (len_r >= sq_sum) begin
          len_nxt  = len_r - sq_sum;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          k_nxt     = 2'd0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        rem_nxt   = {2'd0, num_w[47:16]};
        qn_nxt    = num_w[15:0];
        cnt_nxt   = 4'd15;
        state_nxt = S_DIV;
      end
      // rounded quotient, one bit a cycle
      S_DIV: begin
        rem_nxt = qbit ? (trial - {1'b0, dvs}) : trial;
        qn_nxt  = qfin;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          nrm_nxt[vi_r][k_r] = cur_comp[VecW-1] ? nrm_t'(-qclamp) : nrm_t'(qclamp);
          if (k_r != 2'd2) begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_DIVI;
          end else if (vi_r == VTex2) begin
            state_nxt = deg_r ? S_FIN : S_DET0;
          end else if (vi_r == VBitan) begin
            state_nxt = S_FIN;
          end else begin
            vi_nxt    = vi_r + 3'd1;
            k_nxt     = 2'd0;
            len_nxt   = '0;
            state_nxt = S_SQ;
          end
        end
      end
      // texture determinant sign
      S_DET0: begin
        acc_nxt   = 34'(prod);
        state_nxt = S_DET1;
      end
      S_DET1: begin
        acc_nxt   = comb_v;
        state_nxt = S_DETC;
      end
      S_DETC: begin
        if (acc_r == '0) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          neg_nxt   = acc_r[33];
          k_nxt     = 2'd0;
          ph_nxt    = 2'd0;
          state_nxt = S_CMB;
        end
      end
      // combine normalized edges into raw tangent and bitangent
      S_CMB: begin
        ph_nxt = ph_r + 2'd1;
        unique case (ph_r)
          2'd0: acc_nxt = 34'(prod);
          2'd1: vec_nxt[VTan][k_r] = neg_r ? VecW'(-comb_v) : VecW'(comb_v);
          2'd2: acc_nxt = 34'(prod);
          default: begin
            vec_nxt[VBitan][k_r] = neg_r ? VecW'(-comb_v) : VecW'(comb_v);
            if (k_r == 2'd2) begin
              vi_nxt    = VTan;
              k_nxt     = 2'd0;
              len_nxt   = '0;
              state_nxt = S_SQ;
            end else begin
              k_nxt = k_r + 2'd1;
            end
          end
        endcase
      end
      // hand over once the output register is free
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vec_r   <= vec_nxt;
    nrm_r   <= nrm_nxt;
    vi_r    <= vi_nxt;
    k_r     <= k_nxt;
    ph_r    <= ph_nxt;
    cnt_r   <= cnt_nxt;
    len_r   <= len_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    magsh_r <= magsh_nxt;
    rem_r   <= rem_nxt;
    qn_r    <= qn_nxt;
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    deg_r   <= deg_nxt;
    if (in_fire && slot_r == 2'd0) hold_a_r <= cur;
    if (in_fire && slot_r == 2'd1) hold_b_r <= cur;
    if (state_r == S_FIN && fin_go) begin
      out_deg_r <= deg_r;
      for (int i = 0; i < 3; i++) begin
        out_t_r[i] <= deg_r ? '0 : nrm_r[VTan][i];
        out_b_r[i] <= deg_r ? '0 : nrm_r[VBitan][i];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tangent_x   = out_t_r[0];
  assign out_ch.tangent_y   = out_t_r[1];
  assign out_ch.tangent_z   = out_t_r[2];
  assign out_ch.bitangent_x = out_b_r[0];
  assign out_ch.bitangent_y = out_b_r[1];
  assign out_ch.bitangent_z = out_b_r[2];
  assign out_ch.degenerate  = out_deg_r;

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE)
    else $error("ready raised while sequencer busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_deg_r) &&
      $stable(out_t_r[0]) && $stable(out_b_r[0])))
    else $error("waiting result item changed before it was taken");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("vertex count out of range");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |-> (out_t_r[0] == '0 && out_t_r[1] == '0 &&
      out_t_r[2] == '0 && out_b_r[0] == '0 && out_b_r[1] == '0 && out_b_r[2] == '0))
    else $error("degenerate item with nonzero vectors");

  a_start_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_SQ) |=> slot_r == 2'd0)
    else $error("triangle started without clearing vertex count");

endmodule
